// File: rtl/mnp_pkg.sv
// Shared types and constants for the MIDI note pairing table.
// No dependencies; every rtl file but mnp_ram refers to it by scoped names.
package mnp_pkg;

  localparam int NoteCountDef  = 128;
  localparam int TimeBitsDef   = 32;
  localparam int QueueDepthDef = 2;

  localparam logic [15:0] MinDurReset = 16'd51;

  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  out_note;
    logic [31:0] start_time;
    logic [31:0] duration;
    logic [6:0]  start_velocity;
  } out_item_t;

  typedef enum logic {
    OP_OPEN  = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] timestamp;
  } job_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_CALC = 1'b1
  } back_state_e;

  typedef struct packed {
    logic calc;
    logic pop;
  } back_status_t;

endpackage

// File: rtl/midi_note_pairing_table.sv
// MIDI note pairing table top level: front classifier, job queue, note table back end.
// Depends on mnp_pkg, mnp_front, mnp_queue, mnp_back, mnp_ram.
// A close of a sounding note passes the front slot, the job queue, the table read and the
// compute state, which waits out output stalls, before its result is registered. An open or
// a close of a silent note is done in idle; the registered table read needs the compute state.
// Reset clears all active bits at once and loads min_duration with 51; no clearing pass.
module midi_note_pairing_table #(
  parameter int NoteCount = mnp_pkg::NoteCountDef,
  parameter int TimeBits  = mnp_pkg::TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mnp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mnp_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0]           min_dur_q;
  logic                  push, q_ready, q_valid, pop;
  mnp_pkg::job_t         push_job, head_job;
  mnp_pkg::back_status_t bk_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dur_q <= mnp_pkg::MinDurReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_dur_q <= cfg_data_i;
    end
  end

  mnp_front #(
    .NoteCount (NoteCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .job_o      (push_job),
    .q_ready_i  (q_ready)
  );

  mnp_queue #(
    .Depth (mnp_pkg::QueueDepthDef)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .head_o  (head_job),
    .pop_i   (pop)
  );

  mnp_back #(
    .NoteCount (NoteCount),
    .TimeBits  (TimeBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head_job),
    .pop_o       (pop),
    .min_dur_i   (min_dur_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .status_o    (bk_status)
  );

`ifndef SYNTHESIS
  a_new_result_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_status.calc))
    else $error("result appeared without a table compute cycle");

  a_no_pop_while_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.calc |-> !bk_status.pop)
    else $error("queue popped while a close is in progress");

  a_duration_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.duration >= 32'(min_dur_q)))
    else $error("duration below configured minimum");
`endif

endmodule

// File: rtl/mnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mnp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/mnp_front.sv
// Front end: takes events, drops ignored ones, classifies open or close.
// Depends on mnp_pkg.
module mnp_front #(
  parameter int NoteCount = mnp_pkg::NoteCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mnp_pkg::in_item_t in_item_i,
  output logic             push_o,
  output mnp_pkg::job_t    job_o,
  input  logic             q_ready_i
);

  localparam logic [7:0] NoteLim = 8'(NoteCount);

  logic          slot_valid_q, slot_valid_d;
  mnp_pkg::job_t slot_q;
  logic          accept, keep, is_open;

  assign in_stall_o = slot_valid_q && !q_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = slot_valid_q && q_ready_i;
  assign job_o      = slot_q;

  // Controller events, unused kinds and notes past the table are dropped here.
  assign keep = ((in_item_i.req_type == mnp_pkg::KIND_NOTE_ON) ||
                 (in_item_i.req_type == mnp_pkg::KIND_NOTE_OFF)) &&
                ({1'b0, in_item_i.note_number} < NoteLim);
  assign is_open = (in_item_i.req_type == mnp_pkg::KIND_NOTE_ON) &&
                   (in_item_i.velocity != 7'd0);

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (push_o) begin
      slot_valid_d = 1'b0;
    end
    if (accept && keep) begin
      slot_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      slot_q.op        <= is_open ? mnp_pkg::OP_OPEN : mnp_pkg::OP_CLOSE;
      slot_q.note      <= in_item_i.note_number;
      slot_q.vel       <= in_item_i.velocity;
      slot_q.timestamp <= in_item_i.timestamp;
    end
  end

endmodule

// File: rtl/mnp_queue.sv
// Short FIFO of classified jobs between front and back.
// Depends on mnp_pkg.
module mnp_queue #(
  parameter int Depth = mnp_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mnp_pkg::job_t job_i,
  output logic          ready_o,
  output logic          valid_o,
  output mnp_pkg::job_t head_o,
  input  logic          pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mnp_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/mnp_back.sv
// Back end: note table read-modify-write, duration clamp, output register.
// Depends on mnp_pkg and mnp_ram.
module mnp_back #(
  parameter int NoteCount = mnp_pkg::NoteCountDef,
  parameter int TimeBits  = mnp_pkg::TimeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  mnp_pkg::job_t         head_i,
  output logic                  pop_o,
  input  logic [15:0]           min_dur_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mnp_pkg::out_item_t    out_item_o,
  output mnp_pkg::back_status_t status_o
);

  localparam int IdxW   = (NoteCount > 1) ? $clog2(NoteCount) : 1;
  localparam int EntryW = TimeBits + 7;

  mnp_pkg::back_state_e state_q, state_d;
  logic [NoteCount-1:0] active_q;
  mnp_pkg::job_t        cur_q;
  logic                 out_valid_q;
  mnp_pkg::out_item_t   out_q;

  logic [IdxW-1:0]     head_idx, cur_idx;
  logic                head_active, out_free;
  logic                ram_we, ram_re, load_out;
  logic [EntryW-1:0]   rd_data;
  logic [TimeBits-1:0] start_t, end_t, diff, min_ext, dur;
  logic                too_short;

  assign head_idx    = head_i.note[IdxW-1:0];
  assign cur_idx     = cur_q.note[IdxW-1:0];
  assign head_active = active_q[head_idx];
  assign out_free    = !out_valid_q || !out_stall_i;

  mnp_ram #(
    .Width (EntryW),
    .Depth (NoteCount)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (head_idx),
    .wr_data_i ({TimeBits'(head_i.timestamp), head_i.vel}),
    .rd_en_i   (ram_re),
    .rd_addr_i (head_idx),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnp_pkg::BK_IDLE: begin
        if (q_valid_i && (head_i.op == mnp_pkg::OP_CLOSE) && head_active) begin
          state_d = mnp_pkg::BK_CALC;
        end
      end
      mnp_pkg::BK_CALC: begin
        if (out_free) begin
          state_d = mnp_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      mnp_pkg::BK_IDLE: begin
        pop_o  = q_valid_i;
        ram_we = q_valid_i && (head_i.op == mnp_pkg::OP_OPEN);
        // Close of an inactive note: pop and drop.
        ram_re = q_valid_i && (head_i.op == mnp_pkg::OP_CLOSE) && head_active;
      end
      mnp_pkg::BK_CALC: begin
        load_out = out_free;
      end
    endcase
  end

  // Difference wraps modulo the time width; a negative one clamps to the minimum.
  assign start_t   = rd_data[EntryW-1:7];
  assign end_t     = TimeBits'(cur_q.timestamp);
  assign diff      = end_t - start_t;
  assign min_ext   = TimeBits'(min_dur_i);
  assign too_short = diff[TimeBits-1] || (diff < min_ext);
  assign dur       = too_short ? min_ext : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mnp_pkg::BK_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        active_q[head_idx] <= 1'b1;
      end
      if (load_out) begin
        active_q[cur_idx] <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      cur_q <= head_i;
    end
    if (load_out) begin
      out_q.out_note       <= cur_q.note;
      out_q.start_time     <= 32'(start_t);
      out_q.duration       <= 32'(dur);
      out_q.start_velocity <= rd_data[6:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_item_o    = out_q;
  assign status_o.calc = (state_q == mnp_pkg::BK_CALC);
  assign status_o.pop  = pop_o;

endmodule

// File: dv/midi_note_pairing_table_tb.sv
`timescale 1ns / 1ps
// Testbench for midi_note_pairing_table: random and directed MIDI events with a note-table
// predictor in a scoreboard class. Depends on mnp_pkg and the midi_note_pairing_table RTL.
module midi_note_pairing_table_tb;
  import mnp_pkg::*;

  localparam logic [1:0] KindControl = 2'd2;
  localparam logic [1:0] KindUnused  = 2'd3;
  localparam int NoteSlots     = 128;
  localparam int SettleCycles  = 10;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 140;

  class note_pair_scoreboard;
    bit          note_open [NoteSlots];
    logic [31:0] onset_time [NoteSlots];
    logic [6:0]  onset_vel [NoteSlots];
    logic [15:0] min_len;
    out_item_t   awaited_notes [$];
    int unsigned err_count;

    function new();
      min_len   = MinDurReset;
      err_count = 0;
      foreach (note_open[i]) note_open[i] = 1'b0;
    endfunction

    // Update the note table for one accepted event; queue the note it completes, if any.
    function void note_event(in_item_t ev);
      logic [31:0] span;
      out_item_t   done;
      if (ev.req_type != KIND_NOTE_ON && ev.req_type != KIND_NOTE_OFF) return;
      if (ev.req_type == KIND_NOTE_ON && ev.velocity != 7'd0) begin
        onset_time[ev.note_number] = ev.timestamp;
        onset_vel[ev.note_number]  = ev.velocity;
        note_open[ev.note_number]  = 1'b1;
        return;
      end
      if (!note_open[ev.note_number]) return;
      span = ev.timestamp - onset_time[ev.note_number];
      // a negative span means time ran backwards: clamp like a short note
      if (span[31] || span < {16'd0, min_len}) span = {16'd0, min_len};
      done.out_note       = ev.note_number;
      done.start_time     = onset_time[ev.note_number];
      done.duration       = span;
      done.start_velocity = onset_vel[ev.note_number];
      awaited_notes.insert(awaited_notes.size(), done);
      note_open[ev.note_number] = 1'b0;
    endfunction

    function void check_note(out_item_t got);
      out_item_t want;
      if (awaited_notes.size() == 0) begin
        $error("unexpected note: out_note %0d start_time %0h", got.out_note, got.start_time);
        err_count++;
        return;
      end
      want = awaited_notes.pop_front();
      if (got.out_note !== want.out_note) begin
        $error("out_note: expected %0d, got %0d", want.out_note, got.out_note);
        err_count++;
      end
      if (got.start_time !== want.start_time) begin
        $error("start_time: expected %0h, got %0h", want.start_time, got.start_time);
        err_count++;
      end
      if (got.duration !== want.duration) begin
        $error("duration: expected %0h, got %0h", want.duration, got.duration);
        err_count++;
      end
      if (got.start_velocity !== want.start_velocity) begin
        $error("start_velocity: expected %0d, got %0d", want.start_velocity,
               got.start_velocity);
        err_count++;
      end
    endfunction

    function void report_leftover();
      if (awaited_notes.size() != 0) begin
        $error("%0d notes never came out", awaited_notes.size());
        err_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  note_pair_scoreboard board = new();

  bit          tx_lazy;
  bit          rx_lazy;
  bit          long_hold_req;
  logic [31:0] song_time;
  logic [6:0]  note_pool [8];

  midi_note_pairing_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (out_fire) board.check_note(out_item_o);
    if (in_fire) board.note_event(in_item_i);
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls per transfer, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned hold_n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_n = LongHold;
      end else begin
        hold_n = rx_lazy ? $urandom_range(0, 9) : 0;
      end
      if (hold_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic in_item_t make_event(logic [1:0] kind, logic [6:0] note,
                                          logic [6:0] vel, logic [31:0] stamp);
    in_item_t ev;
    ev.req_type    = kind;
    ev.note_number = note;
    ev.velocity    = vel;
    ev.timestamp   = stamp;
    return ev;
  endfunction

  task automatic send_event(input in_item_t ev);
    int unsigned gap;
    gap = tx_lazy ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every pending note, then let the pipeline settle.
  task automatic drain_notes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.awaited_notes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_min_len(input logic [15:0] value);
    drain_notes();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.min_len = value;
  endtask

  function automatic in_item_t random_event();
    int unsigned pick;
    logic [1:0]  kind;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] stamp;
    note = ($urandom_range(0, 99) < 75) ? note_pool[$urandom_range(0, 7)]
                                        : 7'($urandom_range(0, 127));
    vel  = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      kind = KIND_NOTE_ON;
      vel  = 7'($urandom_range(1, 127));
    end else if (pick < 75) begin
      kind = KIND_NOTE_OFF;
    end else if (pick < 87) begin
      kind = KIND_NOTE_ON;
      vel  = 7'd0;
    end else begin
      kind = ($urandom_range(0, 1) != 0) ? KindControl : KindUnused;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) song_time = song_time + $urandom_range(0, 3000);
    else if (pick < 90) song_time = song_time + $urandom_range(0, 200000);
    else if (pick < 95) song_time = song_time - $urandom_range(0, 5000);
    stamp = (pick >= 95) ? $urandom : song_time;
    return make_event(kind, note, vel, stamp);
  endfunction

  task automatic run_random(input int unsigned count, input bit with_hold);
    foreach (note_pool[i]) note_pool[i] = 7'($urandom_range(0, 127));
    song_time = $urandom;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_lazy = ($urandom_range(0, 3) != 0);
        rx_lazy = ($urandom_range(0, 3) != 0);
      end
      // back-to-back offers while the result side holds off: fill the block
      if (with_hold && i == 60) begin
        long_hold_req = 1'b1;
        tx_lazy = 1'b0;
      end
      send_event(random_event());
    end
  endtask

  task automatic run_directed();
    send_event(make_event(KIND_NOTE_ON, 7'd0, 7'd127, 32'h0000_0000));
    send_event(make_event(KIND_NOTE_OFF, 7'd0, 7'd0, 32'h7FFF_FFFF));
    send_event(make_event(KIND_NOTE_ON, 7'd127, 7'd1, 32'hFFFF_FFF0));
    // note-on with zero velocity closes, across the time wrap
    send_event(make_event(KIND_NOTE_ON, 7'd127, 7'd0, 32'h0000_000F));
    // close of a note that is not sounding
    send_event(make_event(KIND_NOTE_OFF, 7'd127, 7'd127, 32'h0000_0100));
    // retrigger, then a close stamped before the retrigger
    send_event(make_event(KIND_NOTE_ON, 7'd85, 7'd85, 32'd1000));
    send_event(make_event(KIND_NOTE_ON, 7'd85, 7'd42, 32'd2000));
    send_event(make_event(KIND_NOTE_OFF, 7'd85, 7'd85, 32'd1500));
    send_event(make_event(KIND_NOTE_ON, 7'd42, 7'd127, 32'hFFFF_FFFF));
    send_event(make_event(KindControl, 7'd42, 7'd42, 32'h5555_5555));
    send_event(make_event(KindUnused, 7'd42, 7'd127, 32'hFFFF_FFFF));
    send_event(make_event(KIND_NOTE_OFF, 7'd42, 7'd127, 32'h7FFF_FFFE));
    send_event(make_event(KIND_NOTE_ON, 7'd1, 7'd64, 32'd100));
    send_event(make_event(KIND_NOTE_OFF, 7'd1, 7'd1, 32'd100));
    send_event(make_event(KIND_NOTE_ON, 7'd2, 7'd3, 32'h8000_0000));
    send_event(make_event(KIND_NOTE_OFF, 7'd2, 7'd0, 32'h0000_0000));
    send_event(make_event(KIND_NOTE_ON, 7'd126, 7'd127, 32'hAAAA_AAAA));
    send_event(make_event(KIND_NOTE_OFF, 7'd126, 7'd2, 32'hAAAA_AAAA + 32'd51));
    send_event(make_event(KIND_NOTE_ON, 7'd126, 7'd126, 32'd0));
    send_event(make_event(KIND_NOTE_ON, 7'd126, 7'd0, 32'd52));
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    tx_lazy       = 1'b1;
    rx_lazy       = 1'b1;
    long_hold_req = 1'b0;
    song_time     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(PhaseItems, 1'b0);
    write_min_len(16'd0);
    run_directed();
    run_random(PhaseItems, 1'b1);
    write_min_len(16'hFFFF);
    run_random(PhaseItems, 1'b0);
    write_min_len(16'($urandom_range(1, 65534)));
    run_random(PhaseItems, 1'b0);
    write_min_len(MinDurReset);
    run_random(PhaseItems, 1'b0);
    drain_notes();

    board.report_leftover();
    if (board.err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
